// File: sv/bglru_pkg.sv
// Shared types and constants for the band-grouped LRU replacement policy.
// No dependencies; imported by bglru_lru, bglru_ctrl, the top level and the testbench.
`timescale 1ns / 1ps
package bglru_pkg;
	localparam int PTR_W = 7;
	localparam int SLOT_W = 6;
	localparam int OFF_W = 32;
	localparam int SHIFT_W = 5;
	localparam int DEF_CACHE_SLOTS = 64;
	localparam logic [PTR_W-1:0] PTR_NONE = 7'd127;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;
	localparam logic [2:0] ADDR_BAND_SHIFT = 3'd0;

	typedef enum logic [1:0] {LRU_MOVE, LRU_UNLINK, LRU_PUSH} lru_op_t;

	typedef struct packed {
		logic vld;
		lru_op_t op;
		logic [PTR_W-1:0] slot;
	} lru_req_t;

	typedef struct packed {
		logic busy;
		logic [PTR_W-1:0] tail;
	} lru_rsp_t;

	typedef enum logic [1:0] {L_IDLE, L_UNLINK, L_PUSH1, L_PUSH2} lru_state_t;

	typedef enum logic [4:0] {
		C_IDLE, C_H_START, C_H_WAIT, C_H_OUT, C_M_SB, C_M_EVCHK,
		C_E_F1, C_E_F2, C_E_WALK, C_E_WAIT, C_E_BFREE, C_M_ALLOC, C_S_SCAN,
		C_F_1, C_F_2, C_F_3, C_F_4, C_F_5, C_N_NEW, C_M_COMMIT, C_M_PWAIT,
		C_M_FIN, C_M_FAIL
	} ctrl_state_t;

	typedef struct packed {
		logic kind;
		logic [OFF_W-1:0] offset;
		logic [SLOT_W-1:0] hit_slot;
	} item_t;

	typedef struct packed {
		logic vld;
		logic evict;
		logic [SLOT_W-1:0] ev_slot;
		logic [SLOT_W-1:0] al_slot;
		logic last;
	} result_t;
endpackage

// File: sv/bglru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bglru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/bglru_lru.sv
// LRU list unit: doubly linked list over slots in two RAMs plus head/tail.
// Depends on bglru_pkg and bglru_ram.
`timescale 1ns / 1ps
module bglru_lru import bglru_pkg::*; #(
	parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  lru_req_t req,
	output lru_rsp_t rsp
);
	localparam int AW = $clog2(CACHE_SLOTS);
	localparam logic [PTR_W-1:0] N_P = PTR_W'(CACHE_SLOTS);

	lru_state_t state_q, state_nxt;
	lru_op_t op_q;
	logic [PTR_W-1:0] slot_q, head_q, tail_q;
	logic [PTR_W-1:0] p_rd, n_rd;
	logic [AW-1:0] raddr;
	logic nxt_we, prv_we;
	logic [AW-1:0] nxt_wa, prv_wa;
	logic [PTR_W-1:0] nxt_wd, prv_wd;

	assign raddr = (state_q == L_IDLE) ? req.slot[AW-1:0] : slot_q[AW-1:0];

	bglru_ram #(.WIDTH(PTR_W), .DEPTH(CACHE_SLOTS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(raddr), .rdata(n_rd)
	);
	bglru_ram #(.WIDTH(PTR_W), .DEPTH(CACHE_SLOTS)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(raddr), .rdata(p_rd)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			L_IDLE: begin
				if (req.vld) begin
					state_nxt = (req.op == LRU_PUSH) ? L_PUSH1 : L_UNLINK;
				end
			end
			L_UNLINK: state_nxt = (op_q == LRU_MOVE) ? L_PUSH1 : L_IDLE;
			L_PUSH1:  state_nxt = L_PUSH2;
			L_PUSH2:  state_nxt = L_IDLE;
			default:  state_nxt = L_IDLE;
		endcase
	end

	always_comb begin
		nxt_we = 1'b0;
		nxt_wa = slot_q[AW-1:0];
		nxt_wd = head_q;
		prv_we = 1'b0;
		prv_wa = slot_q[AW-1:0];
		prv_wd = PTR_NONE;
		case (state_q)
			L_UNLINK: begin
				nxt_we = p_rd < N_P;
				nxt_wa = p_rd[AW-1:0];
				nxt_wd = n_rd;
				prv_we = n_rd < N_P;
				prv_wa = n_rd[AW-1:0];
				prv_wd = p_rd;
			end
			L_PUSH1: begin
				nxt_we = 1'b1;
				prv_we = 1'b1;
			end
			L_PUSH2: begin
				prv_we = head_q < N_P;
				prv_wa = head_q[AW-1:0];
				prv_wd = slot_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp.busy = (state_q != L_IDLE);
	assign rsp.tail = tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			head_q <= PTR_NONE;
			tail_q <= PTR_NONE;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				L_UNLINK: begin
					if (p_rd >= N_P) begin
						head_q <= n_rd;
					end
					if (n_rd >= N_P) begin
						tail_q <= p_rd;
					end
				end
				L_PUSH2: begin
					if (head_q >= N_P) begin
						tail_q <= slot_q;
					end
					head_q <= slot_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && req.vld) begin
			slot_q <= req.slot;
			op_q <= req.op;
		end
	end
endmodule

// File: sv/bglru_ctrl.sv
// Main sequencer: free lists, band table and band chains in RAMs, eviction walk.
// Depends on bglru_pkg and bglru_ram; drives the LRU unit by request struct.
`timescale 1ns / 1ps
module bglru_ctrl import bglru_pkg::*; #(
	parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  item_t              in_item,
	output logic               in_rdy,
	input  logic [SHIFT_W-1:0] band_shift,
	input  logic               can_emit,
	output result_t            res,
	output lru_req_t           lru_req,
	input  lru_rsp_t           lru_rsp
);
	localparam int AW = $clog2(CACHE_SLOTS);
	localparam logic [PTR_W-1:0] N_P = PTR_W'(CACHE_SLOTS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_SLOTS - 1);

	ctrl_state_t state_q, state_nxt;
	item_t item_q;
	logic [PTR_W-1:0] free_head_q, bfree_head_q, cur_q, steps_q, idx_q;
	logic [CACHE_SLOTS-1:0] in_use_q, used_q, sf_wr_q, bf_wr_q;
	logic [AW-1:0] be_q, bf_ra_q, chain_ra_q, s_q, cmp_idx_s1, found_q, f_q;
	logic [SLOT_W-1:0] last_ev_q;
	logic have_ev_q, cmp_vld_s1;
	logic [OFF_W-1:0] band_q;

	logic sf_we, bf_we, ch_we, sb_we, bn_we, bfst_we;
	logic [AW-1:0] sf_wa, bf_wa, ch_wa, sb_wa, bn_wa, bfst_wa;
	logic [PTR_W-1:0] sf_wd, bf_wd, ch_wd;
	logic [AW-1:0] sb_wd, bfst_wd;
	logic [OFF_W-1:0] bn_wd;
	logic [PTR_W-1:0] sf_rd, bf_rd, ch_rd;
	logic [AW-1:0] sb_rd, bfst_rd;
	logic [OFF_W-1:0] bn_rd;

	logic hit_ok, ev_need, be_ok, cur_ok, walk_fire, match, new_ok;
	logic [AW-1:0] e_idx;
	logic [PTR_W-1:0] sf_next, bf_next;

	bglru_ram #(.WIDTH(PTR_W), .DEPTH(CACHE_SLOTS)) u_sfree (
		.clk(clk), .we(sf_we), .waddr(sf_wa), .wdata(sf_wd),
		.raddr(free_head_q[AW-1:0]), .rdata(sf_rd)
	);
	bglru_ram #(.WIDTH(AW), .DEPTH(CACHE_SLOTS)) u_sband (
		.clk(clk), .we(sb_we), .waddr(sb_wa), .wdata(sb_wd),
		.raddr(lru_rsp.tail[AW-1:0]), .rdata(sb_rd)
	);
	bglru_ram #(.WIDTH(OFF_W), .DEPTH(CACHE_SLOTS)) u_bnum (
		.clk(clk), .we(bn_we), .waddr(bn_wa), .wdata(bn_wd),
		.raddr(idx_q[AW-1:0]), .rdata(bn_rd)
	);
	bglru_ram #(.WIDTH(AW), .DEPTH(CACHE_SLOTS)) u_bfirst (
		.clk(clk), .we(bfst_we), .waddr(bfst_wa), .wdata(bfst_wd),
		.raddr(bf_ra_q), .rdata(bfst_rd)
	);
	bglru_ram #(.WIDTH(PTR_W), .DEPTH(CACHE_SLOTS)) u_bfree (
		.clk(clk), .we(bf_we), .waddr(bf_wa), .wdata(bf_wd),
		.raddr(bfree_head_q[AW-1:0]), .rdata(bf_rd)
	);
	bglru_ram #(.WIDTH(PTR_W), .DEPTH(CACHE_SLOTS)) u_chain (
		.clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd),
		.raddr(chain_ra_q), .rdata(ch_rd)
	);

	assign e_idx = bfree_head_q[AW-1:0];
	assign hit_ok = (PTR_W'(item_q.hit_slot) < N_P) && in_use_q[item_q.hit_slot[AW-1:0]];
	assign ev_need = (free_head_q >= N_P) && (lru_rsp.tail < N_P);
	assign be_ok = (PTR_W'(sb_rd) < N_P) && used_q[sb_rd];
	assign cur_ok = (cur_q < N_P) && (steps_q < N_P) && in_use_q[cur_q[AW-1:0]];
	assign walk_fire = cur_ok && (!have_ev_q || can_emit);
	assign match = cmp_vld_s1 && used_q[cmp_idx_s1] && (bn_rd == band_q);
	assign new_ok = bfree_head_q < N_P;
	// untouched list entries read as their reset link i + 1
	assign sf_next = sf_wr_q[s_q] ? sf_rd : PTR_W'(s_q) + PTR_W'(1);
	assign bf_next = bf_wr_q[e_idx] ? bf_rd : PTR_W'(e_idx) + PTR_W'(1);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			C_IDLE:     if (in_vld) state_nxt = in_item.kind ? C_H_START : C_M_SB;
			C_H_START:  state_nxt = hit_ok ? C_H_WAIT : C_H_OUT;
			C_H_WAIT:   if (!lru_rsp.busy) state_nxt = C_H_OUT;
			C_H_OUT:    if (can_emit) state_nxt = C_IDLE;
			C_M_SB:     state_nxt = C_M_EVCHK;
			C_M_EVCHK:  state_nxt = (ev_need && be_ok) ? C_E_F1 : C_M_ALLOC;
			C_E_F1:     state_nxt = C_E_F2;
			C_E_F2:     state_nxt = C_E_WALK;
			C_E_WALK: begin
				if (!cur_ok) state_nxt = C_E_BFREE;
				else if (walk_fire) state_nxt = C_E_WAIT;
			end
			C_E_WAIT:   if (!lru_rsp.busy) state_nxt = C_E_WALK;
			C_E_BFREE:  state_nxt = C_M_ALLOC;
			C_M_ALLOC:  state_nxt = (free_head_q >= N_P) ? C_M_FAIL : C_S_SCAN;
			C_S_SCAN: begin
				if (match) state_nxt = C_F_1;
				else if (cmp_vld_s1 && cmp_idx_s1 == LAST_IDX) state_nxt = C_N_NEW;
			end
			C_F_1:      state_nxt = C_F_2;
			C_F_2:      state_nxt = C_F_3;
			C_F_3:      state_nxt = C_F_4;
			C_F_4:      state_nxt = C_F_5;
			C_F_5:      state_nxt = C_M_COMMIT;
			C_N_NEW:    state_nxt = new_ok ? C_M_COMMIT : C_M_FAIL;
			C_M_COMMIT: state_nxt = C_M_PWAIT;
			C_M_PWAIT:  if (!lru_rsp.busy) state_nxt = C_M_FIN;
			C_M_FIN:    if (can_emit) state_nxt = C_IDLE;
			C_M_FAIL:   if (can_emit) state_nxt = C_IDLE;
			default:    state_nxt = C_IDLE;
		endcase
	end

	always_comb begin
		in_rdy = (state_q == C_IDLE);
		lru_req = '{vld: 1'b0, op: LRU_MOVE, slot: PTR_W'(item_q.hit_slot)};
		res = '{vld: 1'b0, evict: 1'b0, ev_slot: '0, al_slot: '0, last: 1'b0};
		sf_we = 1'b0;   sf_wa = cur_q[AW-1:0];  sf_wd = free_head_q;
		bf_we = 1'b0;   bf_wa = be_q;           bf_wd = bfree_head_q;
		ch_we = 1'b0;   ch_wa = s_q;            ch_wd = ch_rd;
		sb_we = 1'b0;   sb_wa = s_q;            sb_wd = found_q;
		bn_we = 1'b0;   bn_wa = e_idx;          bn_wd = band_q;
		bfst_we = 1'b0; bfst_wa = e_idx;        bfst_wd = s_q;
		case (state_q)
			C_H_START: lru_req.vld = hit_ok;
			C_H_OUT: begin
				res.vld = can_emit;
				res.last = 1'b1;
			end
			C_E_WALK: begin
				if (walk_fire) begin
					lru_req = '{vld: 1'b1, op: LRU_UNLINK, slot: cur_q};
					sf_we = 1'b1;
					res.vld = have_ev_q;
					res.evict = 1'b1;
					res.ev_slot = last_ev_q;
				end
			end
			C_E_BFREE: bf_we = 1'b1;
			C_F_4: ch_we = 1'b1;
			C_F_5: begin
				ch_we = 1'b1;
				ch_wa = f_q;
				ch_wd = PTR_W'(s_q);
				sb_we = 1'b1;
			end
			C_N_NEW: begin
				bn_we = new_ok;
				bfst_we = new_ok;
				ch_we = new_ok;
				ch_wd = PTR_NONE;
				sb_we = new_ok;
				sb_wd = e_idx;
			end
			C_M_COMMIT: lru_req = '{vld: 1'b1, op: LRU_PUSH, slot: PTR_W'(s_q)};
			C_M_FIN, C_M_FAIL: begin
				res.vld = can_emit;
				res.evict = have_ev_q;
				res.ev_slot = have_ev_q ? last_ev_q : '0;
				res.al_slot = (state_q == C_M_FIN) ? SLOT_W'(s_q) : '0;
				res.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			free_head_q <= '0;
			bfree_head_q <= '0;
			in_use_q <= '0;
			used_q <= '0;
			sf_wr_q <= '0;
			bf_wr_q <= '0;
			have_ev_q <= 1'b0;
			steps_q <= '0;
			cmp_vld_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				C_IDLE: begin
					if (in_vld) begin
						have_ev_q <= 1'b0;
						steps_q <= '0;
					end
				end
				C_E_WALK: begin
					if (walk_fire) begin
						free_head_q <= cur_q;
						in_use_q[cur_q[AW-1:0]] <= 1'b0;
						sf_wr_q[cur_q[AW-1:0]] <= 1'b1;
						steps_q <= steps_q + PTR_W'(1);
						have_ev_q <= 1'b1;
					end
				end
				C_E_BFREE: begin
					used_q[be_q] <= 1'b0;
					bf_wr_q[be_q] <= 1'b1;
					bfree_head_q <= PTR_W'(be_q);
				end
				C_M_ALLOC: begin
					idx_q <= '0;
					cmp_vld_s1 <= 1'b0;
				end
				C_S_SCAN: begin
					if (idx_q < N_P) begin
						idx_q <= idx_q + PTR_W'(1);
						cmp_vld_s1 <= 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
				end
				C_N_NEW: begin
					if (new_ok) begin
						bfree_head_q <= bf_next;
						used_q[e_idx] <= 1'b1;
					end
				end
				C_M_COMMIT: begin
					free_head_q <= sf_next;
					in_use_q[s_q] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE:    if (in_vld) item_q <= in_item;
			C_M_EVCHK: begin
				be_q <= sb_rd;
				bf_ra_q <= sb_rd;
			end
			C_E_F2:    cur_q <= PTR_W'(bfst_rd);
			C_E_WALK: begin
				if (walk_fire) begin
					chain_ra_q <= cur_q[AW-1:0];
					last_ev_q <= cur_q[SLOT_W-1:0];
				end
			end
			C_E_WAIT:  if (!lru_rsp.busy) cur_q <= ch_rd;
			C_M_ALLOC: begin
				s_q <= free_head_q[AW-1:0];
				band_q <= item_q.offset >> band_shift;
			end
			C_S_SCAN: begin
				cmp_idx_s1 <= idx_q[AW-1:0];
				if (match) begin
					found_q <= cmp_idx_s1;
					bf_ra_q <= cmp_idx_s1;
				end
			end
			C_F_2: begin
				f_q <= bfst_rd;
				chain_ra_q <= bfst_rd;
			end
			default: begin
			end
		endcase
	end
endmodule

// File: sv/band_grouped_lru_cache_policy_top.sv
// Channel | dir | handshake        | payload
// s_      | in  | tvalid / tready  | tuser: kind; tdata: block_offset, hit_slot
// m_      | out | tvalid / tready  | tuser: evict_valid; tdata: slots; tlast: last
// apb     | cfg | psel/penable     | band_shift at 0x0
// One item at a time. A hit on a slot in use unlinks it and pushes it to the LRU head (two RAMs).
// A miss scans the band table over one RAM read port; an eviction adds
// the band chain walk over the evicted slots.
// Reset clears all control state at once; no clearing pass.
// Results sit in an output register; a stalled m_tready holds the walk.
// Top level of the band-grouped LRU policy; depends on bglru_pkg, bglru_lru, bglru_ctrl.
`timescale 1ns / 1ps
module band_grouped_lru_cache_policy_top import bglru_pkg::*; #(
	parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // block_offset[31:0], hit_slot[37:32], zero pad
	input  logic [0:0]  s_tuser,   // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // evicted_slot[5:0], allocated_slot[11:6], zero pad
	output logic [0:0]  m_tuser,   // evict_valid[0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [SHIFT_W-1:0] band_shift_q;
	item_t in_item;
	result_t res;
	lru_req_t lru_req;
	lru_rsp_t lru_rsp;
	logic can_emit;
	logic out_vld_q, out_ev_q, out_last_q;
	logic [SLOT_W-1:0] out_es_q, out_al_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_BAND_SHIFT) ? {27'd0, band_shift_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_shift_q <= SHIFT_RESET;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_BAND_SHIFT) begin
			band_shift_q <= pwdata[SHIFT_W-1:0];
		end
	end

	assign in_item = '{kind: s_tuser[0], offset: s_tdata[31:0], hit_slot: s_tdata[37:32]};
	assign can_emit = !out_vld_q || m_tready;

	bglru_lru #(.CACHE_SLOTS(CACHE_SLOTS)) u_lru (
		.clk(clk), .arst_n(arst_n), .req(lru_req), .rsp(lru_rsp)
	);

	bglru_ctrl #(.CACHE_SLOTS(CACHE_SLOTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_vld(s_tvalid), .in_item(in_item), .in_rdy(s_tready),
		.band_shift(band_shift_q), .can_emit(can_emit), .res(res),
		.lru_req(lru_req), .lru_rsp(lru_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.vld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			out_ev_q <= res.evict;
			out_es_q <= res.ev_slot;
			out_al_q <= res.al_slot;
			out_last_q <= res.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {4'd0, out_al_q, out_es_q};
	assign m_tuser = out_ev_q;
	assign m_tlast = out_last_q;
endmodule

// File: sv/bglru_chk.sv
// Port-level checker for the band-grouped LRU policy, bound to the top level.
// Depends on band_grouped_lru_cache_policy_top only through the bind below.
`timescale 1ns / 1ps
module bglru_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken right after a transfer");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("input taken in the middle of an eviction run");

	a_no_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[5:0] == 6'd0 && m_tlast)
		else $error("non-eviction result carries a slot or is not final");
endmodule

bind band_grouped_lru_cache_policy_top bglru_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tuser(m_tuser), .m_tlast(m_tlast)
);

// File: tb/sv/band_grouped_lru_cache_policy_top_tb.sv
// Testbench for band_grouped_lru_cache_policy_top: directed and random hit/miss traffic
// checked against a scoreboard that keeps its own LRU and band state.
// Depends on bglru_pkg and the RTL top level only.
`timescale 1ns / 1ps
module band_grouped_lru_cache_policy_top_tb;
	import bglru_pkg::*;

	localparam int NSLOTS = 64;
	localparam int LIMIT = 1000000;
	localparam bit KIND_MISS = 1'b0;
	localparam bit KIND_HIT = 1'b1;
	localparam logic [PTR_W-1:0] NIL = PTR_NONE;

	typedef struct {
		bit ev;
		bit [5:0] es;
		bit [5:0] al;
		bit last;
	} policy_result_t;

	class lru_band_scoreboard;
		bit [4:0] shift;
		bit [6:0] nxt[NSLOTS], prv[NSLOTS], head, tail;
		bit [6:0] chain_nxt[NSLOTS], free_nxt[NSLOTS], free_head;
		bit [31:0] band_no[NSLOTS];
		bit [6:0] first_slot[NSLOTS], page_cnt[NSLOTS];
		bit band_used[NSLOTS];
		bit [6:0] bfree_nxt[NSLOTS], bfree_head;
		bit [6:0] used_cnt;
		bit [31:0] flush_cnt;
		bit in_use[NSLOTS];
		bit [6:0] slot_band[NSLOTS];
		policy_result_t expected_results[$];
		int errors;

		function void clear();
			shift = SHIFT_RESET;
			for (int i = 0; i < NSLOTS; i++) begin
				nxt[i] = NIL; prv[i] = NIL; chain_nxt[i] = 7'd0;
				free_nxt[i] = 7'(i + 1); bfree_nxt[i] = 7'(i + 1);
				band_no[i] = 32'd0; first_slot[i] = 7'd0; page_cnt[i] = 7'd0;
				band_used[i] = 0; in_use[i] = 0; slot_band[i] = 7'd0;
			end
			head = NIL; tail = NIL; free_head = 7'd0; bfree_head = 7'd0;
			used_cnt = 7'd0; flush_cnt = 32'd0; errors = 0;
		endfunction

		function void unlink(bit [6:0] s);
			bit [6:0] p, n;
			p = prv[s]; n = nxt[s];
			if (p < NSLOTS) nxt[p] = n; else head = n;
			if (n < NSLOTS) prv[n] = p; else tail = p;
			nxt[s] = NIL; prv[s] = NIL;
		endfunction

		function void push_head(bit [6:0] s);
			prv[s] = NIL;
			nxt[s] = head;
			if (head < NSLOTS) prv[head] = s; else tail = s;
			head = s;
		endfunction

		function void note_item(bit kind, bit [31:0] off, bit [5:0] hs);
			bit [6:0] evicted[$];
			bit [6:0] s, be, e, f, nx, found;
			bit [5:0] al;
			bit [31:0] band;
			int steps;
			policy_result_t r;
			al = 6'd0;
			if (kind == KIND_HIT) begin
				if (in_use[hs]) begin
					unlink(7'(hs));
					push_head(7'(hs));
				end
				r = '{0, 0, 0, 1};
				expected_results.push_back(r);
				return;
			end
			if (free_head >= NSLOTS && tail < NSLOTS) begin
				be = slot_band[tail] & 7'd63;
				flush_cnt++;
				if (band_used[be]) begin
					s = first_slot[be];
					steps = 0;
					while (s < NSLOTS && steps < NSLOTS && in_use[s]) begin
						nx = chain_nxt[s];
						free_nxt[s] = free_head;
						free_head = s;
						unlink(s);
						in_use[s] = 0;
						used_cnt = used_cnt - 7'd1;
						evicted.push_back(s);
						steps++;
						s = nx;
					end
					band_used[be] = 0;
					page_cnt[be] = 7'd0;
					bfree_nxt[be] = bfree_head;
					bfree_head = be;
				end
			end
			s = free_head;
			if (s < NSLOTS) begin
				band = off >> shift;
				found = NIL;
				for (int i = 0; i < NSLOTS; i++)
					if (found == NIL && band_used[i] && band_no[i] == band) found = 7'(i);
				e = NIL;
				if (found < NSLOTS) begin
					f = first_slot[found] & 7'd63;
					page_cnt[found] = page_cnt[found] + 7'd1;
					chain_nxt[s] = chain_nxt[f];
					chain_nxt[f] = s;
					e = found;
				end else if (bfree_head < NSLOTS) begin
					e = bfree_head;
					bfree_head = bfree_nxt[e];
					bfree_nxt[e] = NIL;
					band_used[e] = 1;
					page_cnt[e] = 7'd1;
					band_no[e] = band;
					first_slot[e] = s;
					chain_nxt[s] = NIL;
				end
				if (e < NSLOTS) begin
					free_head = free_nxt[s];
					free_nxt[s] = NIL;
					in_use[s] = 1;
					slot_band[s] = e;
					push_head(s);
					used_cnt = used_cnt + 7'd1;
					al = s[5:0];
				end
			end
			if (evicted.size() == 0) begin
				r = '{0, 0, al, 1};
				expected_results.push_back(r);
			end else begin
				foreach (evicted[i]) begin
					r.ev = 1;
					r.es = evicted[i][5:0];
					r.al = (i == evicted.size() - 1) ? al : 6'd0;
					r.last = (i == evicted.size() - 1);
					expected_results.push_back(r);
				end
			end
		endfunction

		function void check_result(bit ev, bit [5:0] es, bit [5:0] al, bit last);
			policy_result_t w;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result ev=%0d es=%0d al=%0d last=%0d",
					$time, ev, es, al, last);
				errors++;
				return;
			end
			w = expected_results.pop_front();
			if (w.ev != ev || w.es != es || w.al != al || w.last != last) begin
				$display("%0t: expected ev=%0d es=%0d al=%0d last=%0d, got ev=%0d es=%0d al=%0d last=%0d",
					$time, w.ev, w.es, w.al, w.last, ev, es, al, last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [15:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	lru_band_scoreboard sb;
	bit quiet;
	bit long_hold;
	int cycles;
	bit [31:0] band_base[8];

	band_grouped_lru_cache_policy_top dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(s_tuser[0], s_tdata[31:0], s_tdata[37:32]);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser[0], m_tdata[5:0], m_tdata[11:6], m_tlast);
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result sink with random back-pressure and one long hold
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 0;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			m_tready <= 1;
		end
	end

	task automatic send_item(bit kind, bit [31:0] off, bit [5:0] hs);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {2'b00, hs, off};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic write_shift(bit [4:0] v);
		s_tvalid <= 0;
		while (sb.expected_results.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= ADDR_BAND_SHIFT; pwdata <= {27'd0, v};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.shift = v;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic random_miss();
		bit [31:0] off;
		case ($urandom_range(0, 9))
			0, 1: off = $urandom();
			default: off = band_base[$urandom_range(0, 7)] + $urandom_range(0, 63);
		endcase
		send_item(KIND_MISS, off, 6'($urandom_range(0, 63)));
	endtask

	task automatic random_phase(bit [4:0] sh, int n, bit with_hold);
		write_shift(sh);
		foreach (band_base[i]) band_base[i] = $urandom();
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == n / 2) long_hold = 1;
			if (sh == 5'd31 && i > 3 * n / 4) quiet = 1;
			if ($urandom_range(0, 3) == 0)
				send_item(KIND_HIT, $urandom(), 6'($urandom_range(0, 63)));
			else
				random_miss();
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		quiet = 0; long_hold = 0;
		arst_n = 0;
		s_tvalid = 0; s_tdata = 0; s_tuser = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		write_shift(5'd4);
		send_item(KIND_HIT, 32'd0, 6'd0);
		send_item(KIND_MISS, 32'd0, 6'd63);
		send_item(KIND_HIT, 32'hFFFF_FFFF, 6'd0);
		send_item(KIND_HIT, 32'd0, 6'd63);
		send_item(KIND_MISS, 32'hFFFF_FFFF, 6'd0);
		send_item(KIND_MISS, 32'd5, 6'd0);
		send_item(KIND_MISS, 32'hFFFF_FFF0, 6'd0);
		send_item(KIND_HIT, 32'd0, 6'd1);
		send_item(KIND_HIT, 32'd0, 6'd0);
		write_shift(5'd31);
		send_item(KIND_MISS, 32'h8000_0000, 6'd0);
		send_item(KIND_MISS, 32'h7FFF_FFFF, 6'd0);
		write_shift(5'd0);
		send_item(KIND_MISS, 32'd5, 6'd0);
		send_item(KIND_MISS, 32'd5, 6'd0);
		send_item(KIND_HIT, 32'd0, 6'd3);

		// random
		random_phase(5'd0, 60, 1);
		random_phase(5'd5, 60, 0);
		random_phase(5'($urandom_range(1, 30)), 55, 0);
		random_phase(5'd31, 55, 0);

		s_tvalid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
